// File: sv/csc_pkg.sv
package csc_pkg;

  // Field widths
  localparam int COORD_W         = 24;
  localparam int RAD_W           = 20;
  localparam int NORM_W          = 16;
  localparam int NORMAL_FRAC_DEF = 14;

  // Datapath widths
  localparam int DIFF_W = COORD_W + 1;            // signed coordinate difference
  localparam int MAG_W  = DIFF_W;                 // magnitude of a difference
  localparam int DIR_W  = 28;                     // normalized direction, top bit at 27
  localparam int POS_W  = $clog2(MAG_W + 1);      // shift amount, 0..MAG_W
  localparam int PROD_W = DIR_W + 1 + DIFF_W;     // signed direction x difference
  localparam int SUM_W  = PROD_W + 1;             // cross / dot sums
  localparam int SPAN_W = DIR_W + MAG_W + 1;      // segment span along direction
  localparam int SQ_W   = 2 * DIR_W + 1;          // squared length
  localparam int RT_W   = (SQ_W + 1) / 2;         // length (square root)

  typedef struct packed {
    logic signed [COORD_W-1:0] seg_start_x;
    logic signed [COORD_W-1:0] seg_start_y;
    logic signed [COORD_W-1:0] seg_end_x;
    logic signed [COORD_W-1:0] seg_end_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [RAD_W-1:0]   circle_radius;
  } csc_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic        [RAD_W-1:0]  pen_depth;
  } csc_out_t;

endpackage

// File: sv/circle_segment_collision.sv
// Channel  | Ports                        | Handshake
// ---------+------------------------------+-------------------------------------------
// input    | start, busy, in_data         | item taken at clk edge with start && !busy
// result   | out_valid, out_data          | one-cycle strobe, one result per item
//
// Throughput: one item per cycle, every cycle. Each item passes stages A..F, the
// bit-per-stage square root (RT_W stages), stage G, the bit-per-stage dividers
// (DIV_Q stages) and the result register, in that order.
// Reset (rst_n, synchronous) clears all valid bits; busy is high only in reset.
// The receiver cannot stall: results leave on out_valid and are not held.
module circle_segment_collision #(
  parameter int NORMAL_FRAC_BITS = csc_pkg::NORMAL_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  csc_pkg::csc_in_t   in_data,
  output logic               out_valid,
  output csc_pkg::csc_out_t  out_data
);

  localparam int DIFF_W = csc_pkg::DIFF_W;
  localparam int MAG_W  = csc_pkg::MAG_W;
  localparam int DIR_W  = csc_pkg::DIR_W;
  localparam int POS_W  = csc_pkg::POS_W;
  localparam int PROD_W = csc_pkg::PROD_W;
  localparam int SUM_W  = csc_pkg::SUM_W;
  localparam int SPAN_W = csc_pkg::SPAN_W;
  localparam int RT_W   = csc_pkg::RT_W;
  localparam int RAD_W  = csc_pkg::RAD_W;
  localparam int NORM_W = csc_pkg::NORM_W;

  // All three dividers share one depth so their results line up
  localparam int DIV_Q = (RAD_W > NORMAL_FRAC_BITS + 1) ? RAD_W : NORMAL_FRAC_BITS + 1;
  localparam int DIV_N = RT_W + DIV_Q;
  localparam int OV_W  = (SUM_W - 1 > RT_W + RAD_W) ? SUM_W - 1 : RT_W + RAD_W;
  localparam int LAT   = 8 + RT_W + DIV_Q;

  // Sideband riding alongside the square root
  typedef struct packed {
    logic               ok;      // nonzero, positive side, foot inside segment
    logic [SUM_W-2:0]   xprod;
    logic [RAD_W-1:0]   rad;
    logic [DIR_W-1:0]   axn;
    logic [DIR_W-1:0]   ayn;
    logic               dxpos;
    logic               dyneg;
  } sq_side_t;

  // Sideband riding alongside the dividers
  typedef struct packed {
    logic               ok;
    logic               ovf;     // distance at or past 2^RAD_W
    logic [RAD_W-1:0]   rad;
    logic               dxpos;
    logic               dyneg;
  } dv_side_t;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------
  // Stage A: differences
  // ---------------------------------------------------------------
  logic                     a_vld_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r, a_sdx_r, a_sdy_r;
  logic        [RAD_W-1:0]  a_rad_r;

  always_ff @(posedge clk) begin
    a_dx_r  <= DIFF_W'(in_data.seg_end_x)   - DIFF_W'(in_data.seg_start_x);
    a_dy_r  <= DIFF_W'(in_data.seg_end_y)   - DIFF_W'(in_data.seg_start_y);
    a_sdx_r <= DIFF_W'(in_data.seg_start_x) - DIFF_W'(in_data.center_x);
    a_sdy_r <= DIFF_W'(in_data.seg_start_y) - DIFF_W'(in_data.center_y);
    a_rad_r <= in_data.circle_radius;
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= accept;
    end
  end

  // ---------------------------------------------------------------
  // Stage B: magnitudes, signs, dominant magnitude
  // ---------------------------------------------------------------
  logic                     b_vld_r;
  logic        [MAG_W-1:0]  b_ax_r, b_ay_r, b_m_r;
  logic                     b_dxneg_r, b_dxpos_r, b_dyneg_r;
  logic signed [DIFF_W-1:0] b_sdx_r, b_sdy_r;
  logic        [RAD_W-1:0]  b_rad_r;
  logic        [MAG_W-1:0]  b_ax_nxt, b_ay_nxt;

  always_comb begin
    b_ax_nxt = a_dx_r[DIFF_W-1] ? MAG_W'(-a_dx_r) : MAG_W'(a_dx_r);
    b_ay_nxt = a_dy_r[DIFF_W-1] ? MAG_W'(-a_dy_r) : MAG_W'(a_dy_r);
  end

  always_ff @(posedge clk) begin
    b_ax_r    <= b_ax_nxt;
    b_ay_r    <= b_ay_nxt;
    b_m_r     <= (b_ax_nxt > b_ay_nxt) ? b_ax_nxt : b_ay_nxt;
    b_dxneg_r <= a_dx_r[DIFF_W-1];
    b_dxpos_r <= !a_dx_r[DIFF_W-1] && (a_dx_r != '0);
    b_dyneg_r <= a_dy_r[DIFF_W-1];
    b_sdx_r   <= a_sdx_r;
    b_sdy_r   <= a_sdy_r;
    b_rad_r   <= a_rad_r;
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage C: leading-one position -> shift amount
  // ---------------------------------------------------------------
  logic                     c_vld_r;
  logic        [MAG_W-1:0]  c_ax_r, c_ay_r;
  logic        [POS_W-1:0]  c_sh_r, c_sh_nxt;
  logic                     c_nz_r;
  logic                     c_dxneg_r, c_dxpos_r, c_dyneg_r;
  logic signed [DIFF_W-1:0] c_sdx_r, c_sdy_r;
  logic        [RAD_W-1:0]  c_rad_r;

  always_comb begin
    c_sh_nxt = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (b_m_r[k]) c_sh_nxt = POS_W'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    c_ax_r    <= b_ax_r;
    c_ay_r    <= b_ay_r;
    c_sh_r    <= c_sh_nxt;
    c_nz_r    <= (b_m_r != '0);
    c_dxneg_r <= b_dxneg_r;
    c_dxpos_r <= b_dxpos_r;
    c_dyneg_r <= b_dyneg_r;
    c_sdx_r   <= b_sdx_r;
    c_sdy_r   <= b_sdy_r;
    c_rad_r   <= b_rad_r;
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage D: normalize so the dominant component has its top bit at
  // DIR_W-1; (mag << DIR_W) >> (pos+1) covers both shift directions
  // ---------------------------------------------------------------
  logic                     d_vld_r;
  logic        [DIR_W-1:0]  d_axn_r, d_ayn_r, d_axn_nxt, d_ayn_nxt;
  logic signed [DIR_W:0]    d_ux_r, d_uy_r, d_ux_nxt, d_uy_nxt;
  logic        [MAG_W-1:0]  d_ax_r, d_ay_r;
  logic                     d_nz_r, d_dxpos_r, d_dyneg_r;
  logic signed [DIFF_W-1:0] d_sdx_r, d_sdy_r;
  logic        [RAD_W-1:0]  d_rad_r;

  always_comb begin
    d_axn_nxt = DIR_W'({c_ax_r, {DIR_W{1'b0}}} >> c_sh_r);
    d_ayn_nxt = DIR_W'({c_ay_r, {DIR_W{1'b0}}} >> c_sh_r);
    d_ux_nxt  = c_dxneg_r ? -$signed({1'b0, d_axn_nxt}) : $signed({1'b0, d_axn_nxt});
    d_uy_nxt  = c_dyneg_r ? -$signed({1'b0, d_ayn_nxt}) : $signed({1'b0, d_ayn_nxt});
  end

  always_ff @(posedge clk) begin
    d_axn_r   <= d_axn_nxt;
    d_ayn_r   <= d_ayn_nxt;
    d_ux_r    <= d_ux_nxt;
    d_uy_r    <= d_uy_nxt;
    d_ax_r    <= c_ax_r;
    d_ay_r    <= c_ay_r;
    d_nz_r    <= c_nz_r;
    d_dxpos_r <= c_dxpos_r;
    d_dyneg_r <= c_dyneg_r;
    d_sdx_r   <= c_sdx_r;
    d_sdy_r   <= c_sdy_r;
    d_rad_r   <= c_rad_r;
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage E: products (eight multipliers, all independent)
  // ---------------------------------------------------------------
  logic                          e_vld_r;
  logic signed [PROD_W-1:0]      e_cy_r, e_cx_r, e_px_r, e_py_r;
  logic        [2*DIR_W-1:0]     e_qx_r, e_qy_r;
  logic        [DIR_W+MAG_W-1:0] e_spx_r, e_spy_r;
  logic        [DIR_W-1:0]       e_axn_r, e_ayn_r;
  logic                          e_nz_r, e_dxpos_r, e_dyneg_r;
  logic        [RAD_W-1:0]       e_rad_r;

  always_ff @(posedge clk) begin
    e_cy_r    <= d_ux_r * d_sdy_r;
    e_cx_r    <= d_uy_r * d_sdx_r;
    e_px_r    <= d_ux_r * d_sdx_r;
    e_py_r    <= d_uy_r * d_sdy_r;
    e_qx_r    <= d_axn_r * d_axn_r;
    e_qy_r    <= d_ayn_r * d_ayn_r;
    e_spx_r   <= d_axn_r * d_ax_r;
    e_spy_r   <= d_ayn_r * d_ay_r;
    e_axn_r   <= d_axn_r;
    e_ayn_r   <= d_ayn_r;
    e_nz_r    <= d_nz_r;
    e_dxpos_r <= d_dxpos_r;
    e_dyneg_r <= d_dyneg_r;
    e_rad_r   <= d_rad_r;
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= d_vld_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage F: sums. dotn is the negated dot product.
  // ---------------------------------------------------------------
  logic                     f_vld_r;
  logic signed [SUM_W-1:0]  f_cross_r, f_dotn_r;
  logic        [2*RT_W-1:0] f_sq_r;
  logic        [SPAN_W-1:0] f_span_r;
  logic        [DIR_W-1:0]  f_axn_r, f_ayn_r;
  logic                     f_nz_r, f_dxpos_r, f_dyneg_r;
  logic        [RAD_W-1:0]  f_rad_r;

  always_ff @(posedge clk) begin
    f_cross_r <= SUM_W'(e_cy_r) - SUM_W'(e_cx_r);
    f_dotn_r  <= SUM_W'(e_px_r) + SUM_W'(e_py_r);
    f_sq_r    <= (2 * RT_W)'(e_qx_r) + (2 * RT_W)'(e_qy_r);
    f_span_r  <= SPAN_W'(e_spx_r) + SPAN_W'(e_spy_r);
    f_axn_r   <= e_axn_r;
    f_ayn_r   <= e_ayn_r;
    f_nz_r    <= e_nz_r;
    f_dxpos_r <= e_dxpos_r;
    f_dyneg_r <= e_dyneg_r;
    f_rad_r   <= e_rad_r;
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= e_vld_r;
    end
  end

  // ---------------------------------------------------------------
  // Square root of squared length, sideband delayed alongside.
  // Foot test: dot >= 0 and dot <= span, i.e. dotn <= 0 and dotn+span >= 0.
  // ---------------------------------------------------------------
  logic                  sq_vld;
  logic [RT_W-1:0]       sq_len;
  sq_side_t              sq_side_nxt;
  sq_side_t              sq_side_r [RT_W];
  logic signed [SUM_W:0] f_lo_chk;

  csc_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (f_vld_r),
    .in_rad   (f_sq_r),
    .out_vld  (sq_vld),
    .out_root (sq_len)
  );

  always_comb begin
    f_lo_chk          = (SUM_W + 1)'(f_dotn_r) + $signed((SUM_W + 1)'(f_span_r));
    sq_side_nxt.ok    = f_nz_r
                        && !f_cross_r[SUM_W-1]
                        && (f_dotn_r[SUM_W-1] || (f_dotn_r == '0))
                        && !f_lo_chk[SUM_W];
    sq_side_nxt.xprod = f_cross_r[SUM_W-2:0];
    sq_side_nxt.rad   = f_rad_r;
    sq_side_nxt.axn   = f_axn_r;
    sq_side_nxt.ayn   = f_ayn_r;
    sq_side_nxt.dxpos = f_dxpos_r;
    sq_side_nxt.dyneg = f_dyneg_r;
  end

  always_ff @(posedge clk) begin
    sq_side_r[0] <= sq_side_nxt;
    for (int k = 1; k < RT_W; k++) begin
      sq_side_r[k] <= sq_side_r[k-1];
    end
  end

  // ---------------------------------------------------------------
  // Stage G: distance overflow check and divider operands.
  // Normal numerator carries +len/2 for round-half-up.
  // ---------------------------------------------------------------
  logic             g_vld_r;
  logic [DIV_N-1:0] g_numd_r, g_numx_r, g_numy_r;
  logic [RT_W-1:0]  g_len_r;
  dv_side_t         g_side_r;
  sq_side_t         sq_out;

  assign sq_out = sq_side_r[RT_W-1];

  always_ff @(posedge clk) begin
    g_numd_r       <= DIV_N'(sq_out.xprod);
    g_numx_r       <= (DIV_N'(sq_out.ayn) << NORMAL_FRAC_BITS) + DIV_N'(sq_len >> 1);
    g_numy_r       <= (DIV_N'(sq_out.axn) << NORMAL_FRAC_BITS) + DIV_N'(sq_len >> 1);
    g_len_r        <= sq_len;
    g_side_r.ok    <= sq_out.ok;
    g_side_r.ovf   <= OV_W'(sq_out.xprod) >= (OV_W'(sq_len) << RAD_W);
    g_side_r.rad   <= sq_out.rad;
    g_side_r.dxpos <= sq_out.dxpos;
    g_side_r.dyneg <= sq_out.dyneg;
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else begin
      g_vld_r <= sq_vld;
    end
  end

  // ---------------------------------------------------------------
  // Dividers: distance, |normal_x|, |normal_y|
  // ---------------------------------------------------------------
  logic             dv_vld;
  logic [DIV_Q-1:0] dv_qd, dv_qx, dv_qy;
  dv_side_t         dv_side_r [DIV_Q];

  csc_div_pipe #(.QUO_W(DIV_Q), .DEN_W(RT_W)) u_div_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (g_vld_r),
    .in_num  (g_numd_r),
    .in_den  (g_len_r),
    .out_vld (dv_vld),
    .out_quo (dv_qd)
  );

  csc_div_pipe #(.QUO_W(DIV_Q), .DEN_W(RT_W)) u_div_nx (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (g_vld_r),
    .in_num  (g_numx_r),
    .in_den  (g_len_r),
    .out_vld (),
    .out_quo (dv_qx)
  );

  csc_div_pipe #(.QUO_W(DIV_Q), .DEN_W(RT_W)) u_div_ny (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (g_vld_r),
    .in_num  (g_numy_r),
    .in_den  (g_len_r),
    .out_vld (),
    .out_quo (dv_qy)
  );

  always_ff @(posedge clk) begin
    dv_side_r[0] <= g_side_r;
    for (int k = 1; k < DIV_Q; k++) begin
      dv_side_r[k] <= dv_side_r[k-1];
    end
  end

  // ---------------------------------------------------------------
  // Stage H: hit decision and result register
  // ---------------------------------------------------------------
  dv_side_t              h_side;
  logic [RAD_W-1:0]      h_dist;
  logic [NORM_W-1:0]     h_nx, h_ny;
  logic                  h_hit;
  csc_pkg::csc_out_t     out_data_r, out_data_nxt;
  logic                  out_valid_r;

  always_comb begin
    h_side = dv_side_r[DIV_Q-1];
    h_dist = RAD_W'(dv_qd);   // exact whenever ovf is clear
    h_nx   = NORM_W'(dv_qx);
    h_ny   = NORM_W'(dv_qy);
    h_hit  = h_side.ok && !h_side.ovf && (h_dist <= h_side.rad);
    out_data_nxt = '0;
    if (h_hit) begin
      out_data_nxt.hit       = 1'b1;
      out_data_nxt.normal_x  = h_side.dyneg ? -h_nx : h_nx;
      out_data_nxt.normal_y  = h_side.dxpos ? -h_ny : h_ny;
      out_data_nxt.pen_depth = h_side.rad - h_dist;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("item accepted without a result after pipeline latency");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without matching accepted item");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.normal_x == '0) && (out_data.normal_y == '0) && (out_data.pen_depth == '0))
    else $error("miss result carries nonzero fields");

endmodule

// File: sv/csc_sqrt_pipe.sv
module csc_sqrt_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [2*csc_pkg::RT_W-1:0] in_rad,
  output logic                       out_vld,
  output logic [csc_pkg::RT_W-1:0]   out_root
);

  localparam int RW = csc_pkg::RT_W;
  localparam int VW = 2 * RW;

  logic [VW-1:0] rem_r [RW];
  logic [VW-1:0] res_r [RW];
  logic [RW-1:0] vld_r;

  // One result bit per stage, most significant first
  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int I = RW - 1 - j;
    localparam logic [VW-1:0] BIT = VW'(1) << (2 * I);

    logic [VW-1:0] rem_p, res_p, trial, rem_nxt, res_nxt;
    logic          vld_p;

    if (j == 0) begin : g_first
      assign rem_p = in_rad;
      assign res_p = '0;
      assign vld_p = in_vld;
    end else begin : g_rest
      assign rem_p = rem_r[j-1];
      assign res_p = res_r[j-1];
      assign vld_p = vld_r[j-1];
    end

    always_comb begin
      trial = res_p + BIT;
      if (rem_p >= trial) begin
        rem_nxt = rem_p - trial;
        res_nxt = (res_p >> 1) + BIT;
      end else begin
        rem_nxt = rem_p;
        res_nxt = res_p >> 1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      res_r[j] <= res_nxt;
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_p;
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = res_r[RW-1][RW-1:0];

endmodule

// File: sv/csc_div_pipe.sv
module csc_div_pipe #(
  parameter int QUO_W = csc_pkg::RAD_W,
  parameter int DEN_W = csc_pkg::RT_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [DEN_W+QUO_W-1:0] in_num,
  input  logic [DEN_W-1:0]       in_den,
  output logic                   out_vld,
  output logic [QUO_W-1:0]       out_quo
);

  localparam int NUM_W = DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [QUO_W-1:0] vld_r;

  // Restoring division, one quotient bit per stage; num < den << QUO_W
  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int I = QUO_W - 1 - j;

    logic [NUM_W-1:0] rem_p, rem_nxt;
    logic [DEN_W-1:0] den_p;
    logic [QUO_W-1:0] quo_p, quo_nxt;
    logic [NUM_W:0]   diff;
    logic             vld_p;

    if (j == 0) begin : g_first
      assign rem_p = in_num;
      assign den_p = in_den;
      assign quo_p = '0;
      assign vld_p = in_vld;
    end else begin : g_rest
      assign rem_p = rem_r[j-1];
      assign den_p = den_r[j-1];
      assign quo_p = quo_r[j-1];
      assign vld_p = vld_r[j-1];
    end

    always_comb begin
      diff    = {1'b0, rem_p} - ((NUM_W + 1)'(den_p) << I);
      rem_nxt = rem_p;
      quo_nxt = quo_p;
      if (!diff[NUM_W]) begin
        rem_nxt    = diff[NUM_W-1:0];
        quo_nxt[I] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      den_r[j] <= den_p;
      quo_r[j] <= quo_nxt;
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_p;
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];

endmodule

// File: tb/sv/csc_checker.sv
`timescale 1ns / 100ps

module csc_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  csc_pkg::csc_in_t  in_data,
  input  logic              out_valid,
  input  csc_pkg::csc_out_t out_data,
  output int                errors,
  output int                pending
);

  localparam int NFRAC   = csc_pkg::NORMAL_FRAC_DEF;
  localparam int TOP_BIT = 28;

  csc_pkg::csc_out_t contact_q[$];

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic csc_pkg::csc_out_t contact_of(csc_pkg::csc_in_t it);
    longint sx, sy, ex, ey, px, py, dx, dy, ux, uy, cr, dt, sp, nx, ny;
    longint unsigned ax, ay, m, len, distance, rad, q;
    int shr, shl;
    csc_pkg::csc_out_t r;
    r = '0;
    sx = it.seg_start_x; sy = it.seg_start_y;
    ex = it.seg_end_x;   ey = it.seg_end_y;
    px = it.center_x;    py = it.center_y;
    rad = it.circle_radius;
    dx = ex - sx; dy = ey - sy;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    m = ax > ay ? ax : ay;
    if (m == 0) return r;
    shr = 0; shl = 0;
    while ((m >> shr) >= (64'd1 << TOP_BIT)) shr++;
    while ((m << shl) < (64'd1 << (TOP_BIT - 1))) shl++;
    ax = (ax >> shr) << shl;
    ay = (ay >> shr) << shl;
    ux = dx < 0 ? -longint'(ax) : longint'(ax);
    uy = dy < 0 ? -longint'(ay) : longint'(ay);
    len = isqrt(ax * ax + ay * ay);
    cr = ux * (sy - py) - uy * (sx - px);
    if (cr < 0) return r;           // center behind the edge
    distance = unsigned'(cr) / len;
    if (distance > rad) return r;   // too far away
    dt = ux * (px - sx) + uy * (py - sy);
    sp = ux * dx + uy * dy;
    if (dt < 0 || dt > sp) return r; // foot off either end
    q = ((ay << NFRAC) + (len >> 1)) / len;
    nx = dy < 0 ? -longint'(q) : longint'(q);
    q = ((ax << NFRAC) + (len >> 1)) / len;
    ny = dx > 0 ? -longint'(q) : longint'(q);
    q = rad - distance;
    r.hit       = 1'b1;
    r.normal_x  = nx[csc_pkg::NORM_W-1:0];
    r.normal_y  = ny[csc_pkg::NORM_W-1:0];
    r.pen_depth = q[csc_pkg::RAD_W-1:0];
    return r;
  endfunction

  assign pending = contact_q.size();

  always @(posedge clk) begin
    csc_pkg::csc_out_t want;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (start && !busy) contact_q.push_back(contact_of(in_data));
      if (out_valid) begin
        if (contact_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", out_data);
          errors <= errors + 1;
        end else begin
          want = contact_q.pop_front();
          if (want !== out_data) begin
            if (errors < 10)
              $display("mismatch: expected %p, got %p", want, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY = 8 + csc_pkg::RT_W + 40;  // generous margin over the DUT latency

  logic              clk, rst_n, start, busy, out_valid;
  csc_pkg::csc_in_t  in_data;
  csc_pkg::csc_out_t out_data;
  int                errors, pending;

  circle_segment_collision dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  csc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic csc_pkg::csc_in_t seg_item(longint sx, longint sy, longint ex,
                                                longint ey, longint px, longint py,
                                                longint rad);
    csc_pkg::csc_in_t it;
    it.seg_start_x = sx[csc_pkg::COORD_W-1:0]; it.seg_start_y = sy[csc_pkg::COORD_W-1:0];
    it.seg_end_x   = ex[csc_pkg::COORD_W-1:0]; it.seg_end_y   = ey[csc_pkg::COORD_W-1:0];
    it.center_x    = px[csc_pkg::COORD_W-1:0]; it.center_y    = py[csc_pkg::COORD_W-1:0];
    it.circle_radius = rad[csc_pkg::RAD_W-1:0];
    return it;
  endfunction

  // Called just after a rising edge; returns after the accepting edge and any random idle gap.
  task automatic issue(csc_pkg::csc_in_t it);
    int gap;
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // mostly back-to-back, some short gaps, rare long ones
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : 0;
      default: gap = 0;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Segment plus a center near it: t picks the foot along the edge (out of
  // [0,256] lands past an end), k the offset along the edge normal (negative
  // puts the center behind the edge). Radius is scaled around the distance.
  function automatic csc_pkg::csc_in_t near_segment();
    longint sx, sy, dx, dy, px, py, m, rad;
    int sc, t, k;
    sc = $urandom_range(1, 20);
    sx = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    sy = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    dx = longint'($urandom_range(0, 2 << sc)) - (1 << sc);
    dy = longint'($urandom_range(0, 2 << sc)) - (1 << sc);
    t  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 320)) - 32
                                     : int'($urandom_range(0, 256));
    k  = int'($urandom_range(0, 80)) - 16;
    px = sx + (dx * t + dy * k) / 256;
    py = sy + (dy * t - dx * k) / 256;
    m  = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                   : (dy < 0 ? -dy : dy);
    rad = (m * (k < 0 ? -k : k) / 256) * $urandom_range(50, 200) / 100
          + $urandom_range(0, 3);
    if (rad > (1 << csc_pkg::RAD_W) - 1) rad = (1 << csc_pkg::RAD_W) - 1;
    return seg_item(sx, sy, sx + dx, sy + dy, px, py, rad);
  endfunction

  initial begin
    csc_pkg::csc_in_t it;
    logic [191:0]     raw;
    longint           mx, mn, rmax;
    mx   = (1 << (csc_pkg::COORD_W - 1)) - 1;
    mn   = -(1 << (csc_pkg::COORD_W - 1));
    rmax = (1 << csc_pkg::RAD_W) - 1;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    issue(seg_item(100, 100, 100, 100, 100, 100, 500));        // zero-length edge
    issue(seg_item(0, 0, 2560, 0, 1280, -256, 512));           // hit, horizontal
    issue(seg_item(0, 0, 2560, 0, 1280, 256, 512));            // behind the edge
    issue(seg_item(0, 0, 2560, 0, 1280, -1024, 512));          // too far
    issue(seg_item(0, 0, 2560, 0, -10, -256, 512));            // foot before start
    issue(seg_item(0, 0, 2560, 0, 2570, -256, 512));           // foot past end
    issue(seg_item(0, 0, 2560, 0, 0, -256, 512));              // foot exactly at start
    issue(seg_item(0, 0, 2560, 0, 2560, -256, 512));           // foot exactly at end
    issue(seg_item(0, 0, 2560, 0, 1280, 0, 0));                // center on line, r = 0
    issue(seg_item(0, 0, 2560, 0, 1280, -256, 256));           // distance == radius
    issue(seg_item(0, 0, 0, 2560, 256, 1280, 512));            // vertical edge
    issue(seg_item(0, 2560, 0, 0, -256, 1280, 512));           // vertical, reversed
    issue(seg_item(0, 0, 1000, 1000, 600, 400, 400));          // diagonal tie
    issue(seg_item(0, 0, -1000, 1000, -600, -400, 500));       // diagonal, other quadrant
    issue(seg_item(0, 0, 3, 1, 2, 0, 1));                      // tiny edge
    issue(seg_item(mn, mn, mx, mx, mx, mn, rmax));             // full-range edge
    issue(seg_item(mx, mx, mn, mn, mn, mx, rmax));
    issue(seg_item(mn, 0, mx, 0, 0, mn, rmax));
    issue(seg_item(mx, mn, mn, mx, 0, 0, 0));
    issue(seg_item(mn, mn, mn, mx, mx, 0, rmax));
    issue(seg_item(-1, -1, 0, 0, 0, -1, 1));

    // random: mostly near-contact geometry, some fully random fields
    repeat (900) begin
      if ($urandom_range(0, 4) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it  = csc_pkg::csc_in_t'(raw[$bits(csc_pkg::csc_in_t)-1:0]);
      end else begin
        it = near_segment();
      end
      issue(it);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
